// File: sv/swmf_pkg.sv
// ----------------------------------------------------------------------------
// swmf_pkg: shared types and constants of the sliding window median filter
// Window geometry, line store shape and the request and result payloads.
// ----------------------------------------------------------------------------
package swmf_pkg;

	localparam int WINDOW     = 5;
	localparam int HALF       = WINDOW / 2;
	localparam int SPAN       = 2 * HALF + 1;
	localparam int TAPS       = SPAN * SPAN;
	localparam int MAX_WIDTH  = 2048;
	localparam int MAX_HEIGHT = 4096;
	localparam int PIXEL_BITS = 16;

	// line store: one word per column, holding SPAN-1 older rows
	localparam int NSEG   = SPAN - 1;
	localparam int ADDR_W = $clog2(MAX_WIDTH);
	localparam int WORD_W = NSEG * PIXEL_BITS;

	// register fields and counters
	localparam int WIDTH_W  = 12;
	localparam int HEIGHT_W = 13;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 13;

	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = CFG_IDX_W'(1);

	localparam logic REQ_PIXEL = 1'b0;
	localparam logic REQ_DRAIN = 1'b1;

	typedef logic [PIXEL_BITS-1:0] pixel_t;

	typedef struct packed {
		logic   req_type;
		pixel_t pixel_value;
	} in_req_t;

	typedef struct packed {
		pixel_t median_value;
		logic   last_of_frame;
	} out_res_t;

endpackage

// File: sv/sliding_window_median_filter.sv
// ----------------------------------------------------------------------------
// sliding_window_median_filter
// Streaming median over a zero-padded square window, pixels in raster order.
// ----------------------------------------------------------------------------
// One request is taken per clock while in_ready is high. The result for the
// pixel HALF*width+HALF requests back comes from the request that completes
// its window. That request reads the line store at its accepting edge. In
// the cycle after, the column is built, written back and shifted into the
// window. The window then loads the sorter, the odd-even transposition layers
// run one per stage, and the result is written to the 32-entry result queue.
// in_ready drops only while 32 results are owed downstream. After each frame
// send HALF*width+HALF drain requests. A write to the width or height
// register restarts the frame.
module sliding_window_median_filter (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  swmf_pkg::in_req_t          in_data,
	output logic                       out_valid,
	input  logic                       out_ready,
	output swmf_pkg::out_res_t         out_data,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [swmf_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [swmf_pkg::CFG_DATA_W-1:0] cfg_data
);
	import swmf_pkg::*;

	localparam int FIFO_DEPTH = 32;
	localparam int FP_W = $clog2(FIFO_DEPTH);
	localparam int LAG_W = 14;
	localparam int ROW_W = HEIGHT_W - 1;
	localparam int COL_W = WIDTH_W - 1;

	// configuration registers
	logic [WIDTH_W-1:0]  width_q;
	logic [HEIGHT_W-1:0] height_q;
	logic [WIDTH_W-1:0]  w_eff;
	logic [HEIGHT_W-1:0] h_eff;

	// frame control
	logic [LAG_W-1:0]  in_cnt_q;
	logic [ROW_W-1:0]  row_q;
	logic [COL_W-1:0]  col_q;
	logic [ADDR_W-1:0] ptr_q;
	logic [FP_W:0]     pend_q;

	logic              accept, cfg_wr, out_acc;
	logic [LAG_W-1:0]  lag;
	logic              emit, last;
	logic [TAPS-1:0]   mask;
	logic [ADDR_W-1:0] ptr_nxt;
	pixel_t            sample;

	// line store
	logic [WORD_W-1:0] mem [MAX_WIDTH];
	logic [WORD_W-1:0] rd_s1;
	logic [WORD_W-1:0] fwd_s1;
	logic              fwd_hit_s1;
	logic              v_s1, emit_s1, last_s1;
	logic [ADDR_W-1:0] addr_s1;
	pixel_t            sample_s1;
	logic [TAPS-1:0]   mask_s1;
	logic [WORD_W-1:0] seg_s1;
	logic [WORD_W-1:0] wdata_s1;
	pixel_t            column [SPAN];

	// window
	pixel_t            win_q [SPAN][SPAN];
	logic              emit_s2, last_s2;
	logic [TAPS-1:0]   mask_s2;

	// sorting pipeline
	pixel_t            st_q [TAPS+1][TAPS];
	logic              st_v_q [TAPS+1];
	logic              st_last_q [TAPS+1];

	// result queue
	out_res_t          fifo_q [FIFO_DEPTH];
	logic [FP_W:0]     wr_q, rd_q;

	assign cfg_ready = 1'b1;
	assign cfg_wr    = cfg_valid;
	assign in_ready  = (pend_q < (FP_W+1)'(FIFO_DEPTH));
	assign accept    = in_valid && in_ready;
	assign out_valid = (wr_q != rd_q);
	assign out_acc   = out_valid && out_ready;
	assign out_data  = fifo_q[rd_q[FP_W-1:0]];

	// clamp registers to their legal ranges
	always_comb begin
		if (width_q == '0) w_eff = WIDTH_W'(1);
		else if (width_q > WIDTH_W'(MAX_WIDTH)) w_eff = WIDTH_W'(MAX_WIDTH);
		else w_eff = width_q;
		if (height_q == '0) h_eff = HEIGHT_W'(1);
		else if (height_q > HEIGHT_W'(MAX_HEIGHT)) h_eff = HEIGHT_W'(MAX_HEIGHT);
		else h_eff = height_q;
	end

	// decide emission, frame end and window mask for the request
	always_comb begin
		logic signed [HEIGHT_W+1:0] rr;
		logic signed [WIDTH_W:0]    cc;
		logic [SPAN-1:0]            row_ok, col_ok;
		lag    = LAG_W'(HALF) * LAG_W'(w_eff) + LAG_W'(HALF);
		emit   = (in_cnt_q == lag);
		last   = ({1'b0, row_q} == h_eff - 1'b1) && ({1'b0, col_q} == w_eff - 1'b1);
		sample = (in_data.req_type == REQ_DRAIN) ? '0 : in_data.pixel_value;
		for (int k = 0; k < SPAN; k++) begin
			rr = $signed((HEIGHT_W+2)'(row_q)) + $signed((HEIGHT_W+2)'(HALF - k));
			cc = $signed((WIDTH_W+1)'(col_q)) + $signed((WIDTH_W+1)'(HALF - k));
			row_ok[k] = !rr[HEIGHT_W+1] && (rr[HEIGHT_W:0] < (HEIGHT_W+1)'(h_eff));
			col_ok[k] = !cc[WIDTH_W] && (cc[WIDTH_W-1:0] < w_eff);
		end
		for (int k = 0; k < SPAN; k++) begin
			for (int j = 0; j < SPAN; j++) begin
				mask[k*SPAN+j] = row_ok[k] && col_ok[j];
			end
		end
		if (WIDTH_W'(ptr_q) + WIDTH_W'(1) >= w_eff) ptr_nxt = '0;
		else ptr_nxt = ptr_q + 1'b1;
	end

	// advance frame counters, restart on frame end or on a width or height write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_W'(640);
			height_q <= HEIGHT_W'(480);
			in_cnt_q <= '0;
			row_q    <= '0;
			col_q    <= '0;
			ptr_q    <= '0;
		end else if (cfg_wr && (cfg_index == REG_IMAGE_WIDTH ||
				cfg_index == REG_IMAGE_HEIGHT)) begin
			if (cfg_index == REG_IMAGE_WIDTH) width_q <= cfg_data[WIDTH_W-1:0];
			else height_q <= cfg_data[HEIGHT_W-1:0];
			in_cnt_q <= '0;
			row_q    <= '0;
			col_q    <= '0;
			ptr_q    <= '0;
		end else if (accept) begin
			if (emit && last) begin
				in_cnt_q <= '0;
				row_q    <= '0;
				col_q    <= '0;
				ptr_q    <= '0;
			end else begin
				ptr_q <= ptr_nxt;
				if (!emit) in_cnt_q <= in_cnt_q + 1'b1;
				else if (WIDTH_W'(col_q) + WIDTH_W'(1) >= w_eff) begin
					col_q <= '0;
					row_q <= row_q + 1'b1;
				end else col_q <= col_q + 1'b1;
			end
		end
	end

	// count results owed downstream
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) pend_q <= '0;
		else pend_q <= pend_q + (FP_W+1)'(accept && emit) - (FP_W+1)'(out_acc);
	end

	// read the line store at the request, forward a write to the same column
	always_ff @(posedge clk) begin
		if (accept) begin
			rd_s1      <= mem[ptr_q];
			fwd_hit_s1 <= v_s1 && (addr_s1 == ptr_q);
			fwd_s1     <= wdata_s1;
			addr_s1    <= ptr_q;
			sample_s1  <= sample;
			mask_s1    <= mask;
			last_s1    <= last;
		end
		if (v_s1) mem[addr_s1] <= wdata_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			emit_s1 <= 1'b0;
		end else begin
			v_s1    <= accept;
			emit_s1 <= accept && emit;
		end
	end

	// build the new column and the word to write back
	always_comb begin
		seg_s1    = fwd_hit_s1 ? fwd_s1 : rd_s1;
		column[0] = sample_s1;
		for (int k = 1; k < SPAN; k++) column[k] = seg_s1[(k-1)*PIXEL_BITS +: PIXEL_BITS];
		for (int k = 0; k < NSEG; k++) wdata_s1[k*PIXEL_BITS +: PIXEL_BITS] = column[k];
	end

	// shift the window by one column
	always_ff @(posedge clk) begin
		if (v_s1) begin
			for (int k = 0; k < SPAN; k++) begin
				win_q[k][0] <= column[k];
				for (int j = 1; j < SPAN; j++) win_q[k][j] <= win_q[k][j-1];
			end
			mask_s2 <= mask_s1;
			last_s2 <= last_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) emit_s2 <= 1'b0;
		else emit_s2 <= emit_s1;
	end

	// load the zero-padded window into the sorter
	always_ff @(posedge clk) begin
		for (int k = 0; k < SPAN; k++) begin
			for (int j = 0; j < SPAN; j++) begin
				st_q[0][k*SPAN+j] <= mask_s2[k*SPAN+j] ? win_q[k][j] : '0;
			end
		end
		st_last_q[0] <= last_s2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) st_v_q[0] <= 1'b0;
		else st_v_q[0] <= emit_s2;
	end

	// odd-even transposition layers, one per stage
	for (genvar i = 0; i < TAPS; i++) begin : g_sort
		localparam int PAR = i % 2;
		always_ff @(posedge clk) begin
			for (int e = 0; e < TAPS; e++) begin
				if (e % 2 == PAR && e + 1 < TAPS) begin
					st_q[i+1][e] <= (st_q[i][e] < st_q[i][e+1]) ? st_q[i][e] : st_q[i][e+1];
				end else if (e % 2 != PAR && e > 0) begin
					st_q[i+1][e] <= (st_q[i][e-1] < st_q[i][e]) ? st_q[i][e] : st_q[i][e-1];
				end else begin
					st_q[i+1][e] <= st_q[i][e];
				end
			end
			st_last_q[i+1] <= st_last_q[i];
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) st_v_q[i+1] <= 1'b0;
			else st_v_q[i+1] <= st_v_q[i];
		end
	end

	// queue results, drop them as they are taken
	always_ff @(posedge clk) begin
		if (st_v_q[TAPS]) begin
			fifo_q[wr_q[FP_W-1:0]].median_value  <= st_q[TAPS][TAPS/2];
			fifo_q[wr_q[FP_W-1:0]].last_of_frame <= st_last_q[TAPS];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
		end else begin
			if (st_v_q[TAPS]) wr_q <= wr_q + 1'b1;
			if (out_acc) rd_q <= rd_q + 1'b1;
		end
	end

endmodule

// File: sv/swmf_checker.sv
// ----------------------------------------------------------------------------
// swmf_checker: port-level checks of the median filter
// Watches the request, result and configuration ports over time.
// ----------------------------------------------------------------------------
module swmf_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       in_valid,
	input logic                       in_ready,
	input swmf_pkg::in_req_t          in_data,
	input logic                       out_valid,
	input logic                       out_ready,
	input swmf_pkg::out_res_t         out_data,
	input logic                       cfg_valid,
	input logic                       cfg_ready,
	input logic [swmf_pkg::CFG_IDX_W-1:0]  cfg_index,
	input logic [swmf_pkg::CFG_DATA_W-1:0] cfg_data
);
	import swmf_pkg::*;

	// hold a stalled result
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("stalled result changed");

	// back-pressure only while results wait
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid)
		else $error("request stalled with no result waiting");

	// ready returns only after a result is taken
	a_ready_rise: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(in_ready) |-> $past(out_valid && out_ready))
		else $error("ready rose without a result taken");

endmodule

bind sliding_window_median_filter swmf_checker u_swmf_checker (.*);

// File: verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: self-checking testbench of the sliding window median filter
// Drives requests in raster order with drain padding, writes the geometry
// registers between phases and checks every result against an in-bench model
// of the zero-padded 5x5 median, with random idling on both channels.
// ----------------------------------------------------------------------------
module tb_top;

	timeunit 1ns;
	timeprecision 1ps;

	import swmf_pkg::*;

	localparam int HIST = 2 * HALF * MAX_WIDTH + 2 * HALF + 1;
	localparam int TAIL_CYCLES = 64;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = CFG_IDX_W'(2);
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = CFG_IDX_W'(3);

	logic                  clk;
	logic                  arst_n;
	logic                  in_valid;
	logic                  in_ready;
	in_req_t               in_data;
	logic                  out_valid;
	logic                  out_ready;
	out_res_t              out_data;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	int  hold_left;
	bit  no_idle;
	int  sent_count;
	int  frame_count;
	int  cfg_count;

	sliding_window_median_filter dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// median predictor and store of owed results
	class median_scoreboard;
		out_res_t          owed[$];
		int                errors;
		int                checked;
		logic [15:0]       history[HIST];
		int                items_in;
		int                issued;
		int                row;
		int                col;
		logic [WIDTH_W-1:0]  width_reg;
		logic [HEIGHT_W-1:0] height_reg;

		function new();
			width_reg = 12'd640;
			height_reg = 13'd480;
			restart();
		endfunction

		function void restart();
			items_in = 0;
			issued = 0;
			row = 0;
			col = 0;
		endfunction

		function int eff_width();
			if (width_reg == 0) return 1;
			if (width_reg > MAX_WIDTH) return MAX_WIDTH;
			return int'(width_reg);
		endfunction

		function int eff_height();
			if (height_reg == 0) return 1;
			if (height_reg > MAX_HEIGHT) return MAX_HEIGHT;
			return int'(height_reg);
		endfunction

		task report(string msg);
			$display("MISMATCH at %0t: %s", $realtime, msg);
			errors++;
		endtask

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
			if (idx == REG_IMAGE_WIDTH)
				width_reg = d[WIDTH_W-1:0];
			else if (idx == REG_IMAGE_HEIGHT)
				height_reg = d[HEIGHT_W-1:0];
			else
				return;
			restart();
		endfunction

		function void note_request(in_req_t r);
			int w, h, lag, k, rr, cc, i, j;
			logic [15:0] win[TAPS];
			logic [15:0] v;
			out_res_t res;
			w = eff_width();
			h = eff_height();
			lag = HALF * w + HALF;
			history[items_in % HIST] = (r.req_type == REQ_DRAIN) ? 16'd0 : r.pixel_value;
			items_in++;
			if (items_in <= lag) return;
			// gather the zero-padded window
			k = 0;
			for (int dr = -HALF; dr <= HALF; dr++) begin
				for (int dc = -HALF; dc <= HALF; dc++) begin
					rr = row + dr;
					cc = col + dc;
					win[k] = 16'd0;
					if (rr >= 0 && rr < h && cc >= 0 && cc < w)
						win[k] = history[(rr * w + cc) % HIST];
					k++;
				end
			end
			// insertion sort, take the middle
			for (i = 1; i < TAPS; i++) begin
				v = win[i];
				j = i - 1;
				while (j >= 0 && win[j] > v) begin
					win[j + 1] = win[j];
					j--;
				end
				win[j + 1] = v;
			end
			res.median_value = win[TAPS / 2];
			res.last_of_frame = (issued == w * h - 1);
			owed = {owed, res};
			if (res.last_of_frame) begin
				restart();
			end else begin
				issued++;
				col++;
				if (col >= w) begin
					col = 0;
					row++;
				end
			end
		endfunction

		task check_result(out_res_t got);
			out_res_t want;
			checked++;
			if (owed.size() == 0) begin
				report($sformatf("unexpected result median %h last %b",
					got.median_value, got.last_of_frame));
				return;
			end
			want = owed.pop_front();
			if (got.median_value !== want.median_value)
				report($sformatf("median_value got %h want %h",
					got.median_value, want.median_value));
			if (got.last_of_frame !== want.last_of_frame)
				report($sformatf("last_of_frame got %b want %b",
					got.last_of_frame, want.last_of_frame));
		endtask
	endclass

	median_scoreboard sb = new();

	// clock
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// watchdog
	initial begin
		#40ms;
		$display("Timeout waiting for the filter");
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// mostly short gaps, a few long ones
	function automatic int pick_gap();
		int r;
		if (no_idle) return 0;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 88) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [15:0] pick_pixel();
		case ($urandom_range(0, 7))
			0: return 16'h0000;
			1: return 16'hFFFF;
			2: return 16'($urandom_range(0, 15));
			3: return 16'hFFFF - 16'($urandom_range(0, 15));
			default: return 16'($urandom);
		endcase
	endfunction

	// receiver: check accepted results, stall at random, honour hold-off
	initial begin
		int stall_left;
		stall_left = 0;
		out_ready = 1'b0;
		forever begin
			@(posedge clk);
			if (out_valid && out_ready)
				sb.check_result(out_data);
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
				if (!no_idle && $urandom_range(0, 3) == 0)
					stall_left = pick_gap();
			end
		end
	end

	// offer one request; valid stays high afterwards until lowered or replaced
	task automatic send_request(logic kind, logic [15:0] value);
		int gap;
		in_req_t r;
		gap = pick_gap();
		r.req_type = kind;
		r.pixel_value = value;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= r;
		do @(posedge clk); while (!in_ready);
		sb.note_request(r);
		sent_count++;
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		while (sb.owed.size() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
		wait_idle();
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= d;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		sb.write_reg(idx, d);
		cfg_count++;
	endtask

	// pixels of a frame, then drain padding; pause_at >= 0 waits for results there
	task automatic run_frame(int pause_at);
		int w, h, n;
		w = sb.eff_width();
		h = sb.eff_height();
		n = w * h;
		for (int i = 0; i < n; i++) begin
			if (i == pause_at) begin
				in_valid <= 1'b0;
				while (sb.owed.size() != 0) @(posedge clk);
			end
			if ($urandom_range(0, 19) == 0)
				send_request(REQ_DRAIN, 16'($urandom));
			else
				send_request(REQ_PIXEL, pick_pixel());
		end
		for (int i = 0; i < HALF * w + HALF; i++) begin
			if ($urandom_range(0, 3) == 0)
				send_request(REQ_PIXEL, 16'($urandom));
			else
				send_request(REQ_DRAIN, 16'($urandom));
		end
		frame_count++;
	endtask

	initial begin
		logic [15:0] directed[9];
		int rw, rh;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		cfg_valid = 1'b0;
		cfg_index = REG_IMAGE_WIDTH;
		cfg_data = '0;
		hold_left = 0;
		no_idle = 1'b0;
		sent_count = 0;
		frame_count = 0;
		cfg_count = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: 3x3 frame with extreme values and a drain inside the frame
		directed = '{16'hFFFF, 16'h0000, 16'hFFFF, 16'h8000, 16'hFFFF,
			16'h0001, 16'hFFFF, 16'h7FFF, 16'hFFFF};
		write_reg(REG_IMAGE_WIDTH, 13'd3);
		write_reg(REG_IMAGE_HEIGHT, 13'd3);
		for (int i = 0; i < 9; i++)
			send_request(i == 5 ? REQ_DRAIN : REQ_PIXEL, directed[i]);
		for (int i = 0; i < 2 * 3 + 2; i++)
			send_request(i[0] ? REQ_PIXEL : REQ_DRAIN, 16'hFFFF);
		// zero registers count as one: a single-pixel frame
		write_reg(REG_IMAGE_WIDTH, 13'd0);
		write_reg(REG_IMAGE_HEIGHT, 13'd0);
		send_request(REQ_PIXEL, 16'hFFFF);
		for (int i = 0; i < HALF + HALF; i++)
			send_request(REQ_DRAIN, 16'h0);
		// spare indexes leave the geometry alone
		write_reg(REG_SPARE_2, 13'h1FFF);
		write_reg(REG_SPARE_3, 13'h0AAA);

		// back-pressure: long receiver hold-off while requests keep coming,
		// then a pause until every owed result is out
		write_reg(REG_IMAGE_WIDTH, 13'd40);
		write_reg(REG_IMAGE_HEIGHT, 13'd6);
		no_idle = 1'b1;
		hold_left = 300;
		run_frame(150);
		no_idle = 1'b0;

		// random geometry, mostly small frames, some cut short by a write
		while (sent_count < 710) begin
			no_idle = ($urandom_range(0, 4) == 0);
			rw = $urandom_range(1, 16);
			rh = $urandom_range(1, 8);
			if ($urandom_range(0, 2) != 0)
				write_reg(REG_IMAGE_WIDTH, 13'(rw));
			if ($urandom_range(0, 2) != 0)
				write_reg(REG_IMAGE_HEIGHT, 13'(rh));
			if ($urandom_range(0, 7) == 0) begin
				// partial frame, abandoned by the next register write
				for (int i = $urandom_range(1, 30); i > 0; i--)
					send_request($urandom_range(0, 9) == 0 ? REQ_DRAIN : REQ_PIXEL,
						pick_pixel());
				write_reg(REG_IMAGE_WIDTH, 13'(rw));
			end
			run_frame(-1);
			// frame end restarts the counters: run a second frame back to back
			if ($urandom_range(0, 3) == 0)
				run_frame(-1);
		end
		no_idle = 1'b0;

		// extremes, both frames partial: widest row cut short by the next write, then tallest column
		write_reg(REG_IMAGE_WIDTH, 13'hFFF);
		write_reg(REG_IMAGE_HEIGHT, 13'd1);
		for (int i = 0; i < 40; i++)
			send_request(REQ_PIXEL, pick_pixel());
		write_reg(REG_IMAGE_WIDTH, 13'd1);
		write_reg(REG_IMAGE_HEIGHT, 13'h1FFF);
		for (int i = 0; i < 60; i++)
			send_request($urandom_range(0, 9) == 0 ? REQ_DRAIN : REQ_PIXEL,
				pick_pixel());

		wait_idle();
		$display("Sent %0d requests over %0d frames with %0d register writes",
			sent_count, frame_count, cfg_count);
		$display("Checked %0d results, %0d mismatches", sb.checked, sb.errors);
		if (sb.errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

// File: sliding_window_median_filter.f
sv/swmf_pkg.sv
sv/sliding_window_median_filter.sv
sv/swmf_checker.sv
verif/tb_top.sv
